### sv/lsba_pkg.sv
// Shared types and constants for the low-shelf biquad with automatic preamp.
// Used by lsba_div, lsba_mac and low_shelf_biquad_auto_gain_core; depends on nothing.
package lsba_pkg;
	localparam int CHANNELS      = 2;
	localparam int CH_W          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int WINDOW_LENGTH = 65536;

	localparam int SAMPLE_W = 24;
	localparam int COEF_W   = 32;
	localparam int YHIST_W  = 32;
	localparam int ACC_W    = 66;
	localparam int PRE_W    = 10;
	localparam int WIN_W    = 17;
	localparam int QUO_W    = 30;
	localparam int COEF_SHIFT = 26;

	localparam logic [PRE_W-1:0] PREAMP_MIN  = 10'd100;
	localparam logic [PRE_W-1:0] PREAMP_CAP  = 10'd800;
	localparam logic [PRE_W-1:0] PREAMP_UP   = 10'd10;
	localparam logic [PRE_W-1:0] PREAMP_DOWN = 10'd4;
	localparam logic signed [SAMPLE_W-1:0] ONE_SAMPLE = 24'sd4194304;

	localparam logic [2:0] REG_B0     = 3'd0;
	localparam logic [2:0] REG_B1     = 3'd1;
	localparam logic [2:0] REG_B2     = 3'd2;
	localparam logic [2:0] REG_A1     = 3'd3;
	localparam logic [2:0] REG_A2     = 3'd4;
	localparam logic [2:0] REG_NORM   = 3'd5;
	localparam logic [2:0] REG_PREAMP = 3'd6;

	typedef struct packed {
		logic start;
		logic clr;
		logic neg;
	} mac_ctl_t;
endpackage

### sv/lsba_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on lsba_pkg for widths.
module lsba_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [lsba_pkg::QUO_W-1:0]       dividend,
	input  logic [lsba_pkg::PRE_W-1:0]       divisor,
	output logic [lsba_pkg::QUO_W-1:0]       quotient,
	output logic                             done
);
	logic [lsba_pkg::PRE_W-1:0] rem_q;
	logic [lsba_pkg::PRE_W-1:0] den_q;
	logic [lsba_pkg::QUO_W-1:0] quo_q;
	logic [4:0]                 cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [lsba_pkg::PRE_W:0]   rs;
	logic                       ge;
	logic [lsba_pkg::PRE_W:0]   diff;

	assign rs   = {rem_q, quo_q[lsba_pkg::QUO_W-1]};
	assign ge   = rs >= {1'b0, den_q};
	assign diff = rs - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(lsba_pkg::QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[lsba_pkg::PRE_W-1:0] : rs[lsba_pkg::PRE_W-1:0];
			quo_q <= {quo_q[lsba_pkg::QUO_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;
endmodule

### sv/lsba_mac.sv
// Bit-serial signed multiply-accumulate: one multiplier bit per cycle into a wide sum.
// Depends on lsba_pkg for widths and the control struct.
module lsba_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lsba_pkg::mac_ctl_t                  ctl,
	input  logic signed [lsba_pkg::COEF_W-1:0]  coef,
	input  logic signed [lsba_pkg::YHIST_W-1:0] mult,
	output logic signed [lsba_pkg::ACC_W-1:0]   acc,
	output logic                                done
);
	logic signed [lsba_pkg::ACC_W-1:0]   mcand_q;
	logic        [lsba_pkg::YHIST_W-1:0] mplier_q;
	logic signed [lsba_pkg::ACC_W-1:0]   acc_q;
	logic [4:0]                          cnt_q;
	logic                                busy_q;
	logic                                done_q;
	logic signed [lsba_pkg::COEF_W:0]    coef_x;
	logic signed [lsba_pkg::COEF_W:0]    coef_s;
	logic                                last;

	assign coef_x = {coef[lsba_pkg::COEF_W-1], coef};
	assign coef_s = ctl.neg ? -coef_x : coef_x;
	assign last   = cnt_q == 5'(lsba_pkg::YHIST_W - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mcand_q  <= lsba_pkg::ACC_W'(coef_s);
			mplier_q <= mult;
			if (ctl.clr) begin
				acc_q <= '0;
			end
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= last ? (acc_q - mcand_q) : (acc_q + mcand_q);
			end
			mcand_q  <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign acc  = acc_q;
	assign done = done_q;
endmodule

### sv/low_shelf_biquad_auto_gain_core.sv
// The bit-serial divider scales the sample by the preamp, forming 30 quotient bits. The
// bit-serial multiply-accumulate unit then forms five products of 32 multiplier bits each.
// The finishing state settles history and preamp, and the hand-over state moves the result
// into the output register. The input is ready again on the cycle after the hand-over. If
// the output register is still full, the block waits in the hand-over state until m_tready
// drains it. An item for a channel beyond the built count skips the divider and the
// multiply-accumulate unit and goes straight to the hand-over with a zero sample. One item
// is in work at a time, and the output register holds a result while the next item is
// taken. Coefficients are Q6.26, and samples have 2^22 as 1.0.
module low_shelf_biquad_auto_gain_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // sample_in[23:0]
	input  logic [7:0]  s_tuser,   // channel[2:0], zeros above
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // sample_out[23:0], preamp_now[33:24], zeros above
	output logic [7:0]  m_tuser    // clipped[0], zeros above
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_MAC  = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_WAIT = 3'd4;

	localparam logic [2:0] TERM_B0 = 3'd0;
	localparam logic [2:0] TERM_B1 = 3'd1;
	localparam logic [2:0] TERM_B2 = 3'd2;
	localparam logic [2:0] TERM_A1 = 3'd3;
	localparam logic [2:0] TERM_A2 = 3'd4;

	logic signed [31:0] b0_q, b1_q, b2_q, a1_q, a2_q;
	logic               norm_q;
	logic [9:0]         pstart_q;
	logic [9:0]         preamp_q;
	logic [16:0]        win_q;
	logic               seen_q;

	logic signed [23:0] xh1_q [lsba_pkg::CHANNELS];
	logic signed [23:0] xh2_q [lsba_pkg::CHANNELS];
	logic signed [31:0] yh1_q [lsba_pkg::CHANNELS];
	logic signed [31:0] yh2_q [lsba_pkg::CHANNELS];

	logic [2:0]          state_q;
	logic [2:0]          term_q;
	logic                go_q;
	logic                sign_q;
	logic [lsba_pkg::CH_W-1:0] ch_q;
	logic signed [23:0]  x_q;
	logic signed [23:0]  res_y_q;
	logic                res_clip_q;
	logic [9:0]          res_pre_q;
	logic signed [23:0]  out_y_q;
	logic                out_clip_q;
	logic [9:0]          out_pre_q;
	logic                out_v_q;

	logic                wr_en;
	logic signed [23:0]  s_in;
	logic [2:0]          s_ch;
	logic [24:0]         s_mag;
	logic [30:0]         s_mag100;
	logic                div_start;
	logic [29:0]         quo;
	logic                div_done;
	lsba_pkg::mac_ctl_t  mac_ctl;
	logic signed [31:0]  mac_coef;
	logic signed [31:0]  mac_mult;
	logic signed [65:0]  acc;
	logic                mac_done;
	logic signed [39:0]  y40;
	logic signed [31:0]  ysat;
	logic                clip;
	logic signed [23:0]  yclamp;
	logic [9:0]          p_nx;
	logic [16:0]         w_nx;
	logic                seen_nx;
	logic [29:0]         qneg;
	logic                in_acc;
	logic                out_load;

	assign pready   = 1'b1;
	assign wr_en    = psel && penable && pwrite && pready;
	assign s_in     = $signed(s_tdata);
	assign s_ch     = s_tuser[2:0];
	assign s_mag    = s_in[23] ? 25'(-{s_in[23], s_in}) : {1'b0, s_in};
	assign s_mag100 = {s_mag, 6'd0} + {1'b0, s_mag, 5'd0} + {4'd0, s_mag, 2'd0};
	assign s_tready = state_q == ST_IDLE;
	assign in_acc   = s_tvalid && s_tready;
	assign div_start = in_acc && (32'(s_ch) < lsba_pkg::CHANNELS);
	assign out_load = (state_q == ST_WAIT) && (!out_v_q || m_tready);

	always_comb begin
		case (paddr[4:2])
			lsba_pkg::REG_B0:     prdata = b0_q;
			lsba_pkg::REG_B1:     prdata = b1_q;
			lsba_pkg::REG_B2:     prdata = b2_q;
			lsba_pkg::REG_A1:     prdata = a1_q;
			lsba_pkg::REG_A2:     prdata = a2_q;
			lsba_pkg::REG_NORM:   prdata = {31'd0, norm_q};
			lsba_pkg::REG_PREAMP: prdata = {22'd0, pstart_q};
			default:              prdata = '0;
		endcase
	end

	lsba_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (s_mag100[29:0]),
		.divisor  (preamp_q),
		.quotient (quo),
		.done     (div_done)
	);

	always_comb begin
		mac_ctl.start = go_q;
		mac_ctl.clr   = term_q == TERM_B0;
		mac_ctl.neg   = (term_q == TERM_A1) || (term_q == TERM_A2);
		case (term_q)
			TERM_B0: begin
				mac_coef = b0_q;
				mac_mult = 32'(x_q);
			end
			TERM_B1: begin
				mac_coef = b1_q;
				mac_mult = 32'(xh1_q[ch_q]);
			end
			TERM_B2: begin
				mac_coef = b2_q;
				mac_mult = 32'(xh2_q[ch_q]);
			end
			TERM_A1: begin
				mac_coef = a1_q;
				mac_mult = yh1_q[ch_q];
			end
			default: begin
				mac_coef = a2_q;
				mac_mult = yh2_q[ch_q];
			end
		endcase
	end

	lsba_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.coef   (mac_coef),
		.mult   (mac_mult),
		.acc    (acc),
		.done   (mac_done)
	);

	assign qneg = -quo;
	assign y40  = acc[65:lsba_pkg::COEF_SHIFT];
	assign ysat = (y40 > 40'sd2147483647) ? 32'sh7fffffff :
		(y40 < -40'sd2147483648) ? 32'sh80000000 : y40[31:0];
	assign clip = (y40 > 40'(lsba_pkg::ONE_SAMPLE)) || (y40 < -40'(lsba_pkg::ONE_SAMPLE));
	assign yclamp = (y40 > 40'(lsba_pkg::ONE_SAMPLE)) ? lsba_pkg::ONE_SAMPLE :
		(y40 < -40'(lsba_pkg::ONE_SAMPLE)) ? -lsba_pkg::ONE_SAMPLE : y40[23:0];

	always_comb begin
		p_nx    = preamp_q;
		w_nx    = win_q;
		seen_nx = seen_q;
		if (norm_q && clip) begin
			seen_nx = 1'b1;
			if (p_nx < lsba_pkg::PREAMP_CAP) begin
				p_nx = p_nx + lsba_pkg::PREAMP_UP;
			end
		end
		if (norm_q && (p_nx > lsba_pkg::PREAMP_MIN)) begin
			w_nx = win_q + 17'd1;
			if (32'(w_nx) > lsba_pkg::WINDOW_LENGTH) begin
				if (!seen_nx) begin
					if (p_nx >= lsba_pkg::PREAMP_MIN + lsba_pkg::PREAMP_DOWN) begin
						p_nx = p_nx - lsba_pkg::PREAMP_DOWN;
					end else begin
						p_nx = lsba_pkg::PREAMP_MIN;
					end
				end
				seen_nx = 1'b0;
				w_nx    = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q     <= 32'sd67108864;
			b1_q     <= '0;
			b2_q     <= '0;
			a1_q     <= '0;
			a2_q     <= '0;
			norm_q   <= 1'b0;
			pstart_q <= lsba_pkg::PREAMP_MIN;
			preamp_q <= lsba_pkg::PREAMP_MIN;
			win_q    <= '0;
			seen_q   <= 1'b0;
			state_q  <= ST_IDLE;
			term_q   <= TERM_B0;
			go_q     <= 1'b0;
			out_v_q  <= 1'b0;
			for (int c = 0; c < lsba_pkg::CHANNELS; c++) begin
				xh1_q[c] <= '0;
				xh2_q[c] <= '0;
				yh1_q[c] <= '0;
				yh2_q[c] <= '0;
			end
		end else begin
			go_q <= 1'b0;
			if (wr_en) begin
				case (paddr[4:2])
					lsba_pkg::REG_B0:   b0_q   <= pwdata;
					lsba_pkg::REG_B1:   b1_q   <= pwdata;
					lsba_pkg::REG_B2:   b2_q   <= pwdata;
					lsba_pkg::REG_A1:   a1_q   <= pwdata;
					lsba_pkg::REG_A2:   a2_q   <= pwdata;
					lsba_pkg::REG_NORM: norm_q <= pwdata[0];
					lsba_pkg::REG_PREAMP: begin
						pstart_q <= pwdata[9:0];
						preamp_q <= (pwdata[9:0] < lsba_pkg::PREAMP_MIN) ?
							lsba_pkg::PREAMP_MIN : pwdata[9:0];
					end
					default: ;
				endcase
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= div_start ? ST_DIV : ST_WAIT;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						term_q  <= TERM_B0;
						go_q    <= 1'b1;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (mac_done) begin
						if (term_q == TERM_A2) begin
							state_q <= ST_FIN;
						end else begin
							term_q <= term_q + 3'd1;
							go_q   <= 1'b1;
						end
					end
				end
				ST_FIN: begin
					xh2_q[ch_q] <= xh1_q[ch_q];
					xh1_q[ch_q] <= x_q;
					yh2_q[ch_q] <= yh1_q[ch_q];
					yh1_q[ch_q] <= ysat;
					preamp_q    <= p_nx;
					win_q       <= w_nx;
					seen_q      <= seen_nx;
					state_q     <= ST_WAIT;
				end
				ST_WAIT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sign_q     <= s_in[23];
			ch_q       <= s_ch[lsba_pkg::CH_W-1:0];
			res_y_q    <= '0;
			res_clip_q <= 1'b0;
			res_pre_q  <= preamp_q;
		end
		if ((state_q == ST_DIV) && div_done) begin
			x_q <= sign_q ? qneg[23:0] : quo[23:0];
		end
		if (state_q == ST_FIN) begin
			res_y_q    <= yclamp;
			res_clip_q <= clip;
			res_pre_q  <= p_nx;
		end
		if (out_load) begin
			out_y_q    <= res_y_q;
			out_clip_q <= res_clip_q;
			out_pre_q  <= res_pre_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {6'd0, out_pre_q, out_y_q};
	assign m_tuser  = {7'd0, out_clip_q};

	a_preamp_floor: assert property (@(posedge clk) disable iff (!arst_n)
		preamp_q >= lsba_pkg::PREAMP_MIN)
		else $error("preamp fell below its floor");
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_y_q <= lsba_pkg::ONE_SAMPLE) && (out_y_q >= -lsba_pkg::ONE_SAMPLE))
		else $error("output sample outside the clamp range");
	a_clip_at_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_clip_q) |->
		(out_y_q == lsba_pkg::ONE_SAMPLE) || (out_y_q == -lsba_pkg::ONE_SAMPLE))
		else $error("clipped item not at a rail");
	a_mac_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && div_done) |=> (state_q == ST_MAC && go_q))
		else $error("multiply sequence did not start after divide");
endmodule

### test/tb.sv
// Self-checking testbench for low_shelf_biquad_auto_gain_core: streams samples with a
// built-in predictor of the per-channel biquad, clamp and preamp logic, under varied idling.
// Depends on lsba_pkg and the core; reads no files.
`timescale 1ns / 100ps

module tb;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		logic signed [23:0] smp;
		logic               clip;
		logic [9:0]         pre;
	} filt_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;  // sample_in[23:0]
	logic [7:0]  s_tuser = '0;  // channel[2:0], zeros above
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;       // sample_out[23:0], preamp_now[33:24], zeros above
	logic [7:0]  m_tuser;       // clipped[0], zeros above

	low_shelf_biquad_auto_gain_core dut (.*);

	always #6 clk = ~clk;

	// Predictor state and register copy.
	longint     b0, b1, b2, a1, a2;
	logic       norm_on;
	logic [9:0] preamp;
	int         win_count;
	logic       clip_flag;
	longint     x_one[lsba_pkg::CHANNELS], x_two[lsba_pkg::CHANNELS];
	longint     y_one[lsba_pkg::CHANNELS], y_two[lsba_pkg::CHANNELS];

	filt_result_t expected_q[$];
	int send_idle_pct = 0, recv_stall_pct = 0;
	int errors = 0, items_sent = 0, results_seen = 0, clips_seen = 0;
	int cycles = 0;

	function automatic logic [9:0] preamp_floor(logic [9:0] v);
		return (v < lsba_pkg::PREAMP_MIN) ? lsba_pkg::PREAMP_MIN : v;
	endfunction

	function automatic void model_write(int idx, logic [31:0] val);
		case (idx)
			lsba_pkg::REG_B0: b0 = longint'(signed'(val));
			lsba_pkg::REG_B1: b1 = longint'(signed'(val));
			lsba_pkg::REG_B2: b2 = longint'(signed'(val));
			lsba_pkg::REG_A1: a1 = longint'(signed'(val));
			lsba_pkg::REG_A2: a2 = longint'(signed'(val));
			lsba_pkg::REG_NORM: norm_on = val[0];
			lsba_pkg::REG_PREAMP: preamp = preamp_floor(val[9:0]);
			default: ;
		endcase
	endfunction

	function automatic filt_result_t filter_sample(logic signed [23:0] smp, logic [2:0] ch);
		filt_result_t r;
		longint x, y;
		logic signed [71:0] acc;
		r.smp = '0;
		r.clip = 1'b0;
		if (ch >= lsba_pkg::CHANNELS) begin
			r.pre = preamp;
			return r;
		end
		x = (longint'(smp) * 100) / longint'(preamp);
		acc = 72'(b0 * x) + 72'(b1 * x_one[ch]) + 72'(b2 * x_two[ch])
			- 72'(signed'(72'(a1)) * signed'(72'(y_one[ch])))
			- 72'(signed'(72'(a2)) * signed'(72'(y_two[ch])));
		acc = acc >>> lsba_pkg::COEF_SHIFT;
		y = longint'(acc);
		x_two[ch] = x_one[ch];
		x_one[ch] = x;
		y_two[ch] = y_one[ch];
		y_one[ch] = (y > 64'sd2147483647) ? 64'sd2147483647 :
			(y < -64'sd2147483648) ? -64'sd2147483648 : y;
		if (y > 4194304) begin
			y = 4194304;
			r.clip = 1'b1;
		end else if (y < -4194304) begin
			y = -4194304;
			r.clip = 1'b1;
		end
		if (norm_on && r.clip) begin
			if (preamp < lsba_pkg::PREAMP_CAP) preamp = preamp + lsba_pkg::PREAMP_UP;
			clip_flag = 1'b1;
		end
		if (norm_on && preamp > lsba_pkg::PREAMP_MIN) begin
			win_count++;
			if (win_count > lsba_pkg::WINDOW_LENGTH) begin
				if (!clip_flag)
					preamp = (preamp >= lsba_pkg::PREAMP_MIN + lsba_pkg::PREAMP_DOWN) ?
						preamp - lsba_pkg::PREAMP_DOWN : lsba_pkg::PREAMP_MIN;
				clip_flag = 1'b0;
				win_count = 0;
			end
		end
		r.smp = y[23:0];
		r.pre = preamp;
		return r;
	endfunction

	task automatic send_sample(logic signed [23:0] smp, logic [2:0] ch);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= smp;
		s_tuser <= {5'b0, ch};
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		expected_q.push_back(filter_sample(smp, ch));
		items_sent++;
	endtask

	// Lowers valid at the current step, then waits for every expected result.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(int idx, logic [31:0] val);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 5'(idx * 4);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		model_write(idx, val);
	endtask

	task automatic set_coefs(logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
			logic [31:0] c3, logic [31:0] c4);
		reg_write(lsba_pkg::REG_B0, c0);
		reg_write(lsba_pkg::REG_B1, c1);
		reg_write(lsba_pkg::REG_B2, c2);
		reg_write(lsba_pkg::REG_A1, c3);
		reg_write(lsba_pkg::REG_A2, c4);
	endtask

	function automatic logic signed [23:0] rand_sample();
		case ($urandom_range(7))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return 24'($urandom_range(8191)) - 24'sd4096;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [2:0] rand_channel();
		return ($urandom_range(9) < 8) ? 3'($urandom_range(lsba_pkg::CHANNELS - 1)) :
			3'($urandom);
	endfunction

	function automatic logic [31:0] rand_coef();
		if ($urandom_range(3) == 0) return $urandom;
		return 32'($urandom_range(32'h0800_0000)) - 32'h0400_0000;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
		m_tready <= (recv_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= recv_stall_pct);
	end

	always @(negedge clk) begin
		filt_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (m_tuser[0]) clips_seen++;
			if (expected_q.size() == 0) begin
				$error("result with no item outstanding: data %h user %h", m_tdata, m_tuser);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (m_tdata[23:0] !== e.smp) begin
					$error("sample_out expected %0d actual %0d", e.smp,
						$signed(m_tdata[23:0]));
					errors++;
				end
				if (m_tuser[0] !== e.clip) begin
					$error("clipped expected %0d actual %0d", e.clip, m_tuser[0]);
					errors++;
				end
				if (m_tdata[33:24] !== e.pre) begin
					$error("preamp_now expected %0d actual %0d", e.pre, m_tdata[33:24]);
					errors++;
				end
			end
		end
	end

	task automatic test_identity_extremes();
		send_sample(24'sh7FFFFF, 3'd0);
		send_sample(24'sh800000, 3'd1);
		send_sample(24'sd0, 3'd0);
		send_sample(24'sd4194304, 3'd1);
		send_sample(24'sd4194305, 3'd0);
		send_sample(-24'sd4194305, 3'd1);
		for (int c = 0; c < 8; c++) send_sample(24'sh555555 ^ 24'(c), 3'(c));
	endtask

	task automatic test_coef_extremes();
		set_coefs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		repeat (3) begin
			send_sample(24'sh7FFFFF, 3'd0);
			send_sample(24'sh800000, 3'd1);
		end
		set_coefs(32'h0400_0000, 32'hF800_0000, 32'h0200_0000, 32'hFC00_0000, 32'h0100_0000);
		send_sample(24'sd1000, 3'd0);
		send_sample(-24'sd1000, 3'd0);
	endtask

	task automatic test_preamp();
		reg_write(lsba_pkg::REG_NORM, 32'd1);
		reg_write(lsba_pkg::REG_PREAMP, 32'd50);
		set_coefs(32'h0800_0000, 32'd0, 32'd0, 32'd0, 32'd0);
		repeat (4) send_sample(24'sh7FFFFF, 3'd1);
		send_sample(24'sd1, 3'd7);
		reg_write(lsba_pkg::REG_PREAMP, 32'd795);
		repeat (3) send_sample(24'sh800000, 3'd0);
		reg_write(lsba_pkg::REG_PREAMP, 32'd800);
		send_sample(24'sh7FFFFF, 3'd0);
		reg_write(lsba_pkg::REG_NORM, 32'd0);
		send_sample(24'sh7FFFFF, 3'd1);
	endtask

	task automatic test_random_phase(int idle_pct, int stall_pct, int n);
		drain();
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n; i++) begin
			if (i % 90 == 0) begin
				set_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef());
				reg_write(lsba_pkg::REG_NORM, 32'($urandom_range(1)));
				if ($urandom_range(1))
					reg_write(lsba_pkg::REG_PREAMP, 32'($urandom_range(800, 100)));
			end
			send_sample(rand_sample(), rand_channel());
		end
	endtask

	initial begin
		b0 = 64'sd67108864;
		b1 = 0; b2 = 0; a1 = 0; a2 = 0;
		norm_on = 1'b0;
		preamp = lsba_pkg::PREAMP_MIN;
		win_count = 0;
		clip_flag = 1'b0;
		for (int c = 0; c < lsba_pkg::CHANNELS; c++) begin
			x_one[c] = 0; x_two[c] = 0; y_one[c] = 0; y_two[c] = 0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_identity_extremes();
		test_coef_extremes();
		test_preamp();
		test_random_phase(0, 0, 270);
		test_random_phase(82, 0, 270);
		test_random_phase(0, 82, 270);
		test_random_phase(16, 16, 270);
		drain();
		repeat (20) @(posedge clk);
		$display("Sent %0d items over four idling phases, checked %0d results, %0d clipped.",
			items_sent, results_seen, clips_seen);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
